// ===== rtl/irpw_pkg.sv =====
package irpw_pkg;

   localparam int FRAME_BITS_DEF  = 8;
   localparam int END_GAP_MIN_DEF = 2800;

   localparam int CFG_NUM    = 8;
   localparam int CFG_W      = 16;
   localparam int CSR_ADDR_W = $clog2(CFG_NUM);
   localparam int TS_W       = 32;
   localparam int DATA_W     = 8;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_HEADER_MIN = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_HEADER_MAX = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] CSR_SPACE_MIN  = CSR_ADDR_W'(2);
   localparam logic [CSR_ADDR_W-1:0] CSR_SPACE_MAX  = CSR_ADDR_W'(3);
   localparam logic [CSR_ADDR_W-1:0] CSR_ZERO_MIN   = CSR_ADDR_W'(4);
   localparam logic [CSR_ADDR_W-1:0] CSR_ZERO_MAX   = CSR_ADDR_W'(5);
   localparam logic [CSR_ADDR_W-1:0] CSR_ONE_MIN    = CSR_ADDR_W'(6);
   localparam logic [CSR_ADDR_W-1:0] CSR_ONE_MAX    = CSR_ADDR_W'(7);

   localparam logic [CFG_W-1:0] CFG_RESET [CFG_NUM] = '{
      16'd2200, 16'd2600, 16'd400, 16'd900, 16'd400, 16'd900, 16'd900, 16'd1800
   };

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_HEADER = 4'b0010,
      PH_SPACE  = 4'b0100,
      PH_BIT    = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      CAUSE_NONE        = 3'd0,
      CAUSE_HEADER_MARK = 3'd1,
      CAUSE_HEADER_LEN  = 3'd2,
      CAUSE_SPACE_LEN   = 3'd3,
      CAUSE_END_COUNT   = 3'd4,
      CAUSE_BIT_LEN     = 3'd5,
      CAUSE_TOO_MANY    = 3'd6
   } cause_type;

   typedef struct packed {
      logic [CFG_W-1:0] header_min;
      logic [CFG_W-1:0] header_max;
      logic [CFG_W-1:0] space_min;
      logic [CFG_W-1:0] space_max;
      logic [CFG_W-1:0] zero_min;
      logic [CFG_W-1:0] zero_max;
      logic [CFG_W-1:0] one_min;
      logic [CFG_W-1:0] one_max;
   } window_type;

   typedef struct packed {
      logic            operation;
      logic            level_active;
      logic [TS_W-1:0] timestamp_us;
   } item_type;

   typedef struct packed {
      cause_type         fault_cause;
      logic [DATA_W-1:0] frame_data;
      logic              receive_error;
      logic              frame_ready;
   } result_type;

   function automatic logic in_window(logic [TS_W-1:0] v, logic [CFG_W-1:0] lo,
                                      logic [CFG_W-1:0] hi);
      return (TS_W'(lo) <= v) && (v <= TS_W'(hi));
   endfunction

endpackage

// ===== rtl/irpw_engine.sv =====
module irpw_engine #(
   parameter int FRAME_BITS     = irpw_pkg::FRAME_BITS_DEF,
   parameter int END_GAP_MIN_US = irpw_pkg::END_GAP_MIN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  irpw_pkg::item_type    item,
   input  irpw_pkg::window_type  win,
   output irpw_pkg::result_type  result
);

   localparam int CNT_W = $clog2(FRAME_BITS + 1);

   irpw_pkg::phase_type             phase_ff, phase_in;
   logic [irpw_pkg::TS_W-1:0]       last_ff, last_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [FRAME_BITS-1:0]           store_ff, store_in;
   logic                            complete_ff, complete_in;
   logic                            error_ff, error_in;

   logic [irpw_pkg::TS_W-1:0]       gap;
   logic                            bit_val;
   logic                            take_bit;
   irpw_pkg::cause_type             cause;

   assign gap = item.timestamp_us - last_ff;

   always_comb begin
      phase_in    = phase_ff;
      last_in     = last_ff;
      count_in    = count_ff;
      store_in    = store_ff;
      complete_in = complete_ff;
      error_in    = error_ff;
      cause       = irpw_pkg::CAUSE_NONE;
      take_bit    = 1'b0;
      bit_val     = 1'b0;

      if (item.operation) begin
         complete_in = 1'b0;
         error_in    = 1'b0;
         store_in    = '0;
      end else begin
         last_in = item.timestamp_us;
         if (!complete_ff) begin
            unique case (phase_ff)
               irpw_pkg::PH_IDLE: begin
                  if (item.level_active) begin
                     count_in = '0;
                     phase_in = irpw_pkg::PH_HEADER;
                  end
               end
               irpw_pkg::PH_HEADER: begin
                  if (item.level_active) begin
                     cause = irpw_pkg::CAUSE_HEADER_MARK;
                  end else if (irpw_pkg::in_window(gap, win.header_min, win.header_max)) begin
                     error_in = 1'b0;
                     phase_in = irpw_pkg::PH_SPACE;
                  end else begin
                     cause = irpw_pkg::CAUSE_HEADER_LEN;
                  end
               end
               irpw_pkg::PH_SPACE: begin
                  if (irpw_pkg::in_window(gap, win.space_min, win.space_max)) begin
                     phase_in = irpw_pkg::PH_BIT;
                  end else begin
                     cause = irpw_pkg::CAUSE_SPACE_LEN;
                  end
               end
               irpw_pkg::PH_BIT: begin
                  priority if (irpw_pkg::in_window(gap, win.zero_min, win.zero_max)) begin
                     take_bit = 1'b1;
                  end else if (irpw_pkg::in_window(gap, win.one_min, win.one_max)) begin
                     take_bit = 1'b1;
                     bit_val  = 1'b1;
                  end else if (gap >= irpw_pkg::TS_W'(END_GAP_MIN_US)) begin
                     if (count_ff == CNT_W'(FRAME_BITS)) begin
                        phase_in    = irpw_pkg::PH_IDLE;
                        complete_in = 1'b1;
                     end else begin
                        cause = irpw_pkg::CAUSE_END_COUNT;
                     end
                  end else begin
                     cause = irpw_pkg::CAUSE_BIT_LEN;
                  end
                  if (take_bit) begin
                     if (count_ff == CNT_W'(FRAME_BITS)) begin
                        cause = irpw_pkg::CAUSE_TOO_MANY;
                     end else begin
                        for (int i = 0; i < FRAME_BITS; i++) begin
                           if (count_ff == CNT_W'(FRAME_BITS - 1 - i)) begin
                              store_in[i] = bit_val;
                           end
                        end
                        count_in = count_ff + CNT_W'(1);
                        phase_in = irpw_pkg::PH_SPACE;
                     end
                  end
               end
               default: begin
                  phase_in = irpw_pkg::PH_IDLE;
               end
            endcase
            if (cause != irpw_pkg::CAUSE_NONE) begin
               error_in = 1'b1;
               phase_in = irpw_pkg::PH_IDLE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= irpw_pkg::PH_IDLE;
         last_ff     <= '0;
         count_ff    <= '0;
         store_ff    <= '0;
         complete_ff <= 1'b0;
         error_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         last_ff     <= last_in;
         count_ff    <= count_in;
         store_ff    <= store_in;
         complete_ff <= complete_in;
         error_ff    <= error_in;
      end
   end

   generate
      if (FRAME_BITS >= irpw_pkg::DATA_W) begin : g_data_trunc
         assign result.frame_data = store_in[irpw_pkg::DATA_W-1:0];
      end else begin : g_data_ext
         assign result.frame_data = {{(irpw_pkg::DATA_W - FRAME_BITS){1'b0}}, store_in};
      end
   endgenerate

   assign result.frame_ready   = complete_in;
   assign result.receive_error = error_in;
   assign result.fault_cause   = cause;

endmodule

// ===== rtl/ir_pulse_width_frame_decoder.sv =====
// Channel  Direction  Ports          Contents
// req      in         req_tdata      level_active, timestamp_us
//                     req_tuser      operation
// rsp      out        rsp_tdata      frame_ready, receive_error, frame_data, fault_cause
// csr      in         csr_wen/addr   eight 16-bit window registers, write only
//
// One transaction per cycle sustained while rsp_tready stays high; req passes
// the input register, then decode and result register in the same pass.
// Synchronous reset returns the decoder to idle and the windows to defaults.
// A stalled rsp holds its result; req keeps flowing until the input register
// also fills, then req_tready drops.
module ir_pulse_width_frame_decoder #(
   parameter int FRAME_BITS     = irpw_pkg::FRAME_BITS_DEF,
   parameter int END_GAP_MIN_US = irpw_pkg::END_GAP_MIN_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] level_active, [32:1] timestamp_us
   input  logic [irpw_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [0] operation
   input  logic                                req_tuser,

   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] frame_ready, [1] receive_error, [9:2] frame_data, [12:10] fault_cause
   output logic [irpw_pkg::RSP_TDATA_W-1:0]    rsp_tdata,

   input  logic                                csr_wen,
   input  logic [irpw_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [irpw_pkg::CFG_W-1:0]          csr_wdata
);

   logic [irpw_pkg::CFG_W-1:0] cfg_ff [irpw_pkg::CFG_NUM];
   irpw_pkg::window_type       win;

   logic                       in_valid_ff;
   irpw_pkg::item_type         in_item_ff;
   logic                       advance;

   logic                       out_valid_ff;
   irpw_pkg::result_type       out_ff;
   irpw_pkg::result_type       result;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < irpw_pkg::CFG_NUM; i++) begin
            cfg_ff[i] <= irpw_pkg::CFG_RESET[i];
         end
      end else if (csr_wen) begin
         cfg_ff[csr_addr] <= csr_wdata;
      end
   end

   assign win.header_min = cfg_ff[irpw_pkg::CSR_HEADER_MIN];
   assign win.header_max = cfg_ff[irpw_pkg::CSR_HEADER_MAX];
   assign win.space_min  = cfg_ff[irpw_pkg::CSR_SPACE_MIN];
   assign win.space_max  = cfg_ff[irpw_pkg::CSR_SPACE_MAX];
   assign win.zero_min   = cfg_ff[irpw_pkg::CSR_ZERO_MIN];
   assign win.zero_max   = cfg_ff[irpw_pkg::CSR_ZERO_MAX];
   assign win.one_min    = cfg_ff[irpw_pkg::CSR_ONE_MIN];
   assign win.one_max    = cfg_ff[irpw_pkg::CSR_ONE_MAX];

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.operation    <= req_tuser;
         in_item_ff.level_active <= req_tdata[0];
         in_item_ff.timestamp_us <= req_tdata[irpw_pkg::TS_W:1];
      end
   end

   irpw_engine #(
      .FRAME_BITS     (FRAME_BITS),
      .END_GAP_MIN_US (END_GAP_MIN_US)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .win     (win),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = irpw_pkg::RSP_TDATA_W'(out_ff);

endmodule
